/* rtl/core/lspg_pkg.sv */
package lspg_pkg;

  // Number of LEDs on the strip.
  localparam int LED_COUNT = 10;

  localparam int MODE_W = 4;
  localparam int HUE_W  = 11;
  // Frame index: start frame, LED frames and the tail pad frame.
  localparam int IDX_W  = $clog2(LED_COUNT + 2);

  localparam logic [MODE_W-1:0] RAINBOW_MODE = 4'd13;
  localparam logic [HUE_W-1:0]  HUES         = 11'd1972;
  localparam logic [HUE_W-1:0]  HUE_HALF     = 11'd986;
  localparam logic [HUE_W-1:0]  HUE_SPACING  = 11'd200;
  localparam logic [31:0]       OFF_FRAME    = 32'hE000_0000;

  localparam logic [IDX_W-1:0] LAST_IDX_RAINBOW = IDX_W'(LED_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX_PLAIN   = IDX_W'(LED_COUNT + 1);

  // The queue pointers wrap by overflow, so the depth must be a power of two.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SHOW    = 2'd0,
    OP_BUTTON  = 2'd1,
    OP_RESTORE = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  // One burst to be emitted: the mode in force and the rainbow step.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HUE_W-1:0]  step;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  function automatic logic [31:0] mode_word(logic [MODE_W-1:0] m);
    logic [31:0] w;
    case (m)
      4'd2, 4'd3: w = 32'hF8FF_FFFF;
      4'd4, 4'd5: w = 32'hF0FF_FFFF;
      4'd6, 4'd7: w = 32'hE8FF_FFFF;
      4'd8:       w = 32'hFFA8_1897;
      4'd9:       w = 32'hFF0C_10FF;
      4'd10:      w = 32'hFF00_00FF;
      4'd11:      w = 32'hFF00_FF00;
      4'd12:      w = 32'hFFFF_0000;
      default:    w = 32'hFFFF_FFFF;
    endcase
    return w;
  endfunction

  function automatic logic mode_alt(logic [MODE_W-1:0] m);
    return m inside {4'd1, 4'd3, 4'd5, 4'd7};
  endfunction

  // Folded hue to {FF, R, G, B}.
  function automatic logic [31:0] hue_frame(logic [HUE_W-1:0] hue);
    logic [HUE_W-1:0] h;
    logic [HUE_W-1:0] r;
    logic [HUE_W-1:0] g;
    logic [HUE_W-1:0] b;
    h = (hue >= HUE_HALF) ? HUES - hue : hue;
    if (h < 11'd199) begin
      r = 11'd255; g = 11'd56 + h; b = 11'd57;
    end else if (h < 11'd396) begin
      r = 11'd254 - (h - 11'd199); g = 11'd255; b = 11'd57;
    end else if (h < 11'd592) begin
      r = 11'd57; g = 11'd255; b = 11'd58 + (h - 11'd396);
    end else if (h < 11'd789) begin
      r = 11'd57; g = 11'd254 - (h - 11'd592); b = 11'd255;
    end else begin
      r = 11'd58 + (h - 11'd789); g = 11'd57; b = 11'd255;
    end
    return {8'hFF, r[7:0], g[7:0], b[7:0]};
  endfunction

endpackage

/* rtl/core/lspg_in_if.sv */
interface lspg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] restore_mode;

  modport source (output valid, output opcode, output restore_mode, input ready);
  modport sink   (input valid, input opcode, input restore_mode, output ready);
endinterface

/* rtl/core/lspg_out_if.sv */
interface lspg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] led_frame;
  logic        last_frame;
  logic [3:0]  current_mode;

  modport source (output valid, output led_frame, output last_frame, output current_mode,
                  input ready);
  modport sink   (input valid, input led_frame, input last_frame, input current_mode,
                  output ready);
endinterface

/* rtl/core/lspg_front.sv */
module lspg_front
  import lspg_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  lspg_in_if.sink       in_ch,
  input  logic          fifo_full,
  output cmd_req_t      push_req
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [HUE_W-1:0]  step_r, step_nxt;
  logic              accept;
  logic              emit;
  op_t               op;

  assign in_ch.ready = !fifo_full;
  assign accept      = in_ch.valid && !fifo_full;
  assign op          = op_t'(in_ch.opcode);

  always_comb begin
    mode_nxt = mode_r;
    step_nxt = step_r;
    emit     = 1'b1;
    case (op)
      OP_BUTTON:  mode_nxt = (mode_r >= RAINBOW_MODE) ? '0 : mode_r + 4'd1;
      OP_RESTORE: mode_nxt = (in_ch.restore_mode > 8'(RAINBOW_MODE)) ?
                             '0 : in_ch.restore_mode[MODE_W-1:0];
      OP_TICK: begin
        // A tick only matters while the rainbow is showing.
        emit = (mode_r == RAINBOW_MODE);
        if (emit) begin
          step_nxt = (step_r == HUES - 11'd1) ? '0 : step_r + 11'd1;
        end
      end
      default: ;
    endcase
    if (op != OP_TICK && mode_nxt == RAINBOW_MODE) begin
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      step_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      step_r <= step_nxt;
    end
  end

  assign push_req.valid    = accept && emit;
  assign push_req.cmd.mode = mode_nxt;
  assign push_req.cmd.step = step_nxt;

`ifndef SYNTH
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= RAINBOW_MODE)
    else $error("display mode out of range");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < HUES)
    else $error("rainbow step out of range");
`endif

endmodule

/* rtl/core/lspg_fifo.sv */
module lspg_fifo
  import lspg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_req_t push_req,
  output logic     full,
  output logic     pop_valid,
  output cmd_t     pop_cmd,
  input  logic     pop
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push, do_pop;

  assign full      = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push_req.valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count overflow");
`endif

endmodule

/* rtl/core/lspg_back.sv */
module lspg_back
  import lspg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  lspg_out_if.source out_ch
);

  logic              busy_r;
  logic [IDX_W-1:0]  idx_r;
  logic [HUE_W-1:0]  hue_r;
  logic [MODE_W-1:0] mode_r;

  logic              out_valid_r;
  logic [31:0]       out_frame_r;
  logic              out_last_r;
  logic [MODE_W-1:0] out_mode_r;

  logic              load;
  logic              is_last;
  logic [31:0]       frame;
  logic [HUE_W:0]    hue_sum;
  logic [HUE_W-1:0]  hue_nxt;

  assign load    = !out_valid_r || out_ch.ready;
  assign is_last = (idx_r == ((mode_r == RAINBOW_MODE) ? LAST_IDX_RAINBOW : LAST_IDX_PLAIN));
  // Next burst may start in the cycle the current one finishes.
  assign cmd_pop = cmd_valid && (!busy_r || (load && is_last));

  assign hue_sum = {1'b0, hue_r} + {1'b0, HUE_SPACING};
  assign hue_nxt = (hue_sum >= {1'b0, HUES}) ? HUE_W'(hue_sum - {1'b0, HUES})
                                            : hue_sum[HUE_W-1:0];

  always_comb begin
    if (idx_r == '0) begin
      frame = '0;
    end else if (mode_r == RAINBOW_MODE) begin
      frame = hue_frame(hue_r);
    end else if (mode_alt(mode_r) && !idx_r[0]) begin
      frame = OFF_FRAME;
    end else begin
      frame = mode_word(mode_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= busy_r;
      end
      if (cmd_pop) begin
        busy_r <= 1'b1;
      end else if (load && busy_r && is_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && busy_r) begin
      out_frame_r <= frame;
      out_last_r  <= is_last;
      out_mode_r  <= mode_r;
    end
    if (cmd_pop) begin
      idx_r  <= '0;
      hue_r  <= cmd.step;
      mode_r <= cmd.mode;
    end else if (load && busy_r) begin
      idx_r <= idx_r + IDX_W'(1);
      if (idx_r != '0) begin
        hue_r <= hue_nxt;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.led_frame    = out_frame_r;
  assign out_ch.last_frame   = out_last_r;
  assign out_ch.current_mode = out_mode_r;

`ifndef SYNTH
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && mode_r == RAINBOW_MODE |-> hue_r < HUES)
    else $error("rainbow hue out of range");
  a_last_not_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_frame_r != '0)
    else $error("burst ended on its start frame");
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && !out_last_r |=> out_valid_r)
    else $error("gap inside a frame burst");
`endif

endmodule

/* rtl/core/led_strip_pattern_frame_generator_top.sv */
// Each item's command is queued, then taken by the back end, which registers its frames.
// Throughput: one 32-bit frame per cycle from the output register while the receiver is ready;
// a burst is LED_COUNT + 2 frames (LED_COUNT + 1 for the rainbow).
// Reset: synchronous, active low; mode and rainbow step return to zero and the queue empties.
module led_strip_pattern_frame_generator_top
  import lspg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lspg_in_if.sink     in_ch,
  lspg_out_if.source  out_ch
);

  // The front end decodes each item and updates the mode and rainbow step at once; every item
  // that needs a burst leaves one command in a two-entry queue. The back end turns each command
  // into frames, one per cycle unless stalled, so new items are accepted while a burst goes out.

  cmd_req_t push_req;
  logic     fifo_full;
  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_pop;

  lspg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push_req  (push_req)
  );

  // Commands carry the mode and step as they stood after their item, so each burst
  // is independent of whatever the front end has done since.
  lspg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_req  (push_req),
    .full      (fifo_full),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd),
    .pop       (cmd_pop)
  );

  // The back end walks the start frame, then the LED positions, stepping the hue by the
  // per-LED spacing modulo the hue circle for the rainbow.
  lspg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

/* tb/lspg_frame_checker.sv */
module lspg_frame_checker
  import lspg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_restore_mode,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_led_frame,
  input  logic        out_last_frame,
  input  logic [3:0]  out_current_mode,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0]       frame;
    logic              last;
    logic [MODE_W-1:0] mode;
  } led_word_t;

  led_word_t         frames_due[$];
  logic [MODE_W-1:0] mode_now;
  logic [HUE_W-1:0]  hue_step;
  int                error_tally;

  initial begin
    error_tally = 0;
    mode_now    = '0;
    hue_step    = '0;
  end

  // Word shown on lit positions of the plain modes; unknown modes fall back to white.
  function automatic logic [31:0] plain_word(logic [MODE_W-1:0] m);
    logic [31:0] w;
    w = 32'hFFFF_FFFF;
    if (m == 4'd2 || m == 4'd3) w = 32'hF8FF_FFFF;
    if (m == 4'd4 || m == 4'd5) w = 32'hF0FF_FFFF;
    if (m == 4'd6 || m == 4'd7) w = 32'hE8FF_FFFF;
    if (m == 4'd8)              w = 32'hFFA8_1897;
    if (m == 4'd9)              w = 32'hFF0C_10FF;
    if (m == 4'd10)             w = 32'hFF00_00FF;
    if (m == 4'd11)             w = 32'hFF00_FF00;
    if (m == 4'd12)             w = 32'hFFFF_0000;
    return w;
  endfunction

  // Hue on the folded wheel to a full-brightness colour frame.
  function automatic logic [31:0] rainbow_colour(int hue);
    int folded;
    int red;
    int green;
    int blue;
    folded = (hue >= int'(HUE_HALF)) ? int'(HUES) - hue : hue;
    red    = 57;
    green  = 57;
    blue   = 255;
    if (folded < 199) begin
      red = 255; green = 56 + folded; blue = 57;
    end else if (folded < 396) begin
      red = 254 - (folded - 199); green = 255; blue = 57;
    end else if (folded < 592) begin
      green = 255; blue = 58 + (folded - 396);
    end else if (folded < 789) begin
      green = 254 - (folded - 592);
    end else begin
      red = 58 + (folded - 789);
    end
    return {8'hFF, red[7:0], green[7:0], blue[7:0]};
  endfunction

  task automatic queue_burst();
    int       led_frames;
    led_word_t w;
    led_frames = (mode_now == RAINBOW_MODE) ? LED_COUNT : LED_COUNT + 1;
    w.mode  = mode_now;
    w.frame = '0;
    w.last  = 1'b0;
    frames_due.push_back(w);
    for (int i = 0; i < led_frames; i++) begin
      if (mode_now == RAINBOW_MODE) begin
        w.frame = rainbow_colour((int'(hue_step) + i * int'(HUE_SPACING)) % int'(HUES));
      end else if (mode_now inside {4'd1, 4'd3, 4'd5, 4'd7} && i[0]) begin
        w.frame = OFF_FRAME;
      end else begin
        w.frame = plain_word(mode_now);
      end
      w.last = (i == led_frames - 1);
      frames_due.push_back(w);
    end
  endtask

  task automatic apply_event(op_t op, logic [7:0] rm);
    if (op == OP_TICK) begin
      // Ticks only matter while the rainbow is showing.
      if (mode_now == RAINBOW_MODE) begin
        hue_step = (hue_step == HUES - 11'd1) ? '0 : hue_step + 11'd1;
        queue_burst();
      end
    end else begin
      if (op == OP_BUTTON) begin
        mode_now = (mode_now >= RAINBOW_MODE) ? '0 : mode_now + 4'd1;
      end else if (op == OP_RESTORE) begin
        mode_now = (rm > 8'(RAINBOW_MODE)) ? '0 : rm[MODE_W-1:0];
      end
      if (mode_now == RAINBOW_MODE) hue_step = '0;
      queue_burst();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    error_tally++;
  endtask

  always @(posedge clk) begin : watch_channels
    led_word_t want;
    if (!rst_n) begin
      frames_due.delete();
      mode_now = '0;
      hue_step = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report("unexpected frame", out_led_frame, '0);
        end else begin
          want = frames_due.pop_front();
          if (out_led_frame !== want.frame) report("led_frame", out_led_frame, want.frame);
          if (out_last_frame !== want.last) begin
            report("last_frame", 32'(out_last_frame), 32'(want.last));
          end
          if (out_current_mode !== want.mode) begin
            report("current_mode", 32'(out_current_mode), 32'(want.mode));
          end
        end
      end
      if (in_valid && in_ready) apply_event(op_t'(in_opcode), in_restore_mode);
    end
    errors      <= error_tally;
    outstanding <= frames_due.size();
  end

endmodule

/* tb/led_strip_pattern_frame_generator_top_tb.sv */
module led_strip_pattern_frame_generator_top_tb;
  import lspg_pkg::*;

  // A burst is at most twelve frames, so even a long receiver hold-off with the
  // input stalled keeps the channels quiet for far less than STALL_LIMIT.
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 150;
  localparam int RANDOM_ITEMS  = 84;
  localparam int RAINBOW_TICKS = 16;
  localparam int TAIL_CYCLES   = 20;

  logic        clk;
  logic        rst_n;
  bit          idle_en;
  bit          hold_req;
  int unsigned quiet_cycles;
  int          fault_count;
  int          frames_pending;

  lspg_in_if  in_ch();
  lspg_out_if out_ch();

  led_strip_pattern_frame_generator_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker watches both channels, keeps its own copy of the mode and
  // rainbow step, and hands back its mismatch count and the frames still owed.
  lspg_frame_checker u_frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_opcode        (in_ch.opcode),
    .in_restore_mode  (in_ch.restore_mode),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_led_frame    (out_ch.led_frame),
    .out_last_frame   (out_ch.last_frame),
    .out_current_mode (out_ch.current_mode),
    .errors           (fault_count),
    .outstanding      (frames_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one item, with random idle cycles ahead of it while idling is enabled,
  // and returns at the edge where it is accepted.
  task automatic offer_event(op_t op, logic [7:0] rm);
    while (idle_en && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.restore_mode <= rm;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // The pending count is registered in the checker, so the task first waits on the
  // clock and only then trusts the count to include the item just accepted.
  task automatic wait_drained();
    do @(posedge clk); while (frames_pending != 0);
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  // The hold-off is counted here so that the sender keeps offering items meanwhile.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(0, 99) < 24);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    op_t        op;
    logic [7:0] rm;
    idle_en  = 1'b1;
    hold_req = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_SHOW;
    in_ch.restore_mode <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Show the reset mode, then a tick outside the rainbow, which
    // must produce nothing at all.
    offer_event(OP_SHOW, 8'h00);
    offer_event(OP_TICK, 8'hFF);
    // Alternating patterns, the last plain mode, and a button press into the rainbow.
    offer_event(OP_BUTTON, 8'h00);
    offer_event(OP_RESTORE, 8'd7);
    offer_event(OP_RESTORE, 8'd12);
    offer_event(OP_BUTTON, 8'hA5);
    offer_event(OP_TICK, 8'h00);
    offer_event(OP_TICK, 8'h5A);
    // Showing the rainbow again restarts it from the first hue.
    offer_event(OP_SHOW, 8'h00);
    // A button press from the rainbow wraps the mode round to zero.
    offer_event(OP_BUTTON, 8'h00);
    // Restores beyond the last mode fall back to mode zero.
    offer_event(OP_RESTORE, 8'd14);
    offer_event(OP_RESTORE, 8'd255);
    offer_event(OP_RESTORE, 8'd8);
    offer_event(OP_RESTORE, 8'd9);
    offer_event(OP_RESTORE, 8'd10);
    offer_event(OP_RESTORE, 8'd11);
    offer_event(OP_RESTORE, 8'd3);
    offer_event(OP_RESTORE, 8'd13);
    offer_event(OP_TICK, 8'h00);
    // Restoring the rainbow while it is already showing restarts the step too.
    offer_event(OP_RESTORE, 8'd13);

    // A run of ticks back to back, so the rainbow keeps advancing burst after burst.
    for (int i = 0; i < RAINBOW_TICKS; i++) offer_event(OP_TICK, 8'($urandom));
    offer_event(OP_SHOW, 8'h00);

    // Random part. Most restores name a valid mode, with the rainbow favoured so
    // that ticks have something to advance; the rest cover the out-of-range byte.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 30) hold_req = 1'b1;
      if (i == 45) idle_en = 1'b0;
      if (i == 70) idle_en = 1'b1;
      if (i == 78) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      op = op_t'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1, 2:       rm = 8'd13;
        3, 4, 5, 6:    rm = 8'($urandom_range(0, 13));
        default:       rm = 8'($urandom_range(14, 255));
      endcase
      if (op != OP_RESTORE && $urandom_range(0, 1)) rm = 8'($urandom);
      offer_event(op, rm);
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lspg_pkg.sv
rtl/core/lspg_in_if.sv
rtl/core/lspg_out_if.sv
rtl/core/lspg_front.sv
rtl/core/lspg_fifo.sv
rtl/core/lspg_back.sv
rtl/core/led_strip_pattern_frame_generator_top.sv
tb/lspg_frame_checker.sv
tb/led_strip_pattern_frame_generator_top_tb.sv
